FILE: sv/swre_pkg.sv
package swre_pkg;

  localparam int TIME_W  = 32;
  localparam int BYTES_W = 48;
  localparam int WIN_W   = 20;
  localparam int EDGE_W  = 34;
  localparam int NUM_W   = 80;
  localparam int DEN_W   = 58;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = 64;

  localparam logic [MUL_B_W-1:0] MS_PER_SEC = 16'd1000;

  localparam logic [1:0] REG_WIN_ETA    = 2'd0;
  localparam logic [1:0] REG_WIN_RATE   = 2'd1;
  localparam logic [1:0] REG_DATA_TOTAL = 2'd2;

  localparam logic [WIN_W-1:0]   WIN_ETA_RST  = 20'd10000;
  localparam logic [WIN_W-1:0]   WIN_RATE_RST = 20'd5000;

endpackage

FILE: sv/swre_div.sv
module swre_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [swre_pkg::NUM_W-1:0]    num,
  input  logic [swre_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [swre_pkg::NUM_W-1:0]    quo
);

  logic                          busy;
  logic [6:0]                    cnt;
  logic [swre_pkg::DEN_W-1:0]    rem;
  logic [swre_pkg::DEN_W-1:0]    den_r;
  logic [swre_pkg::DEN_W:0]      rem_sh;
  logic                          fits;

  assign rem_sh = {rem, quo[swre_pkg::NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        den_r <= den;
        quo   <= num;
      end else if (busy) begin
        rem <= fits ? swre_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                    : rem_sh[swre_pkg::DEN_W-1:0];
        quo <= {quo[swre_pkg::NUM_W-2:0], fits};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(swre_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/sliding_window_rate_eta_core.sv
// Each accepted input beat is processed in turn: a scan of the live ring entries (at most
// RING_DEPTH, counted after the insert) through the registered memory read port, two serial
// divisions and the control states, and then the result is placed on the output.
// The input is ready only in idle, so a new beat is not taken until the last one's result is
// on the output; a division is skipped when its estimate is not valid, and a waiting output beat stalls the end.
// Synchronous active-high reset clears the ring to empty, the output valid and the configuration registers to defaults.
module sliding_window_rate_eta_core #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // time_ms[31:0], bytes_done[79:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // rate_bps[47:0], remaining_sec[79:48]
  output logic [1:0]  m_axis_tuser,   // rate_valid[0], eta_valid[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [3:0] {
    IDLE, SCAN, EVICT, CALC, MR, DR, DRW, ME, ME2, ME3, ME4, DE, DEW, OUT
  } state_t;

  state_t state;

  logic [swre_pkg::WIN_W-1:0]   win_eta, win_rate;
  logic [swre_pkg::BYTES_W-1:0] data_total;

  logic [swre_pkg::TIME_W-1:0]  mem_t [RING_DEPTH];
  logic [swre_pkg::BYTES_W-1:0] mem_b [RING_DEPTH];
  logic [swre_pkg::TIME_W-1:0]  rd_t;
  logic [swre_pkg::BYTES_W-1:0] rd_b;

  logic [IW-1:0] oldest;
  logic [CW-1:0] count, iss, proc, kcnt;
  logic          rd_pend;
  logic [swre_pkg::TIME_W-1:0]  newest_t, frt_r, frt_e, dt_r, dt_e;
  logic [swre_pkg::BYTES_W-1:0] newest_b, frb_r, frb_e;
  logic signed [swre_pkg::EDGE_W-1:0] edge_m, edge_r, edge_e;
  logic [swre_pkg::BYTES_W:0] db_r, db_e, rem;
  logic [swre_pkg::PROD_W-1:0] prod;
  logic [swre_pkg::NUM_W-1:0]  acc;
  logic [swre_pkg::DEN_W-1:0]  den_e;
  logic [swre_pkg::BYTES_W-1:0] rate_q;
  logic [31:0] eta_q;
  logic        rate_ok_r, eta_ok_r;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW+1-IW){1'b0}}, base} + {1'b0, i};
    if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
    return s[IW-1:0];
  endfunction

  logic [swre_pkg::TIME_W-1:0]  in_t;
  logic [swre_pkg::BYTES_W-1:0] in_b;
  logic accept, ins, full;
  logic [IW-1:0] wslot, raddr;
  logic [swre_pkg::TIME_W-1:0] nt;
  logic [swre_pkg::WIN_W-1:0]  wmax;
  logic le_m, le_r, le_e;

  assign in_t   = s_axis_tdata[31:0];
  assign in_b   = s_axis_tdata[79:32];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == IDLE);
  assign full   = (count == CW'(RING_DEPTH));
  assign ins    = (count == '0) || (in_t > newest_t);
  assign wslot  = full ? oldest : slot(oldest, count);
  assign raddr  = slot(oldest, iss);
  assign nt     = ins ? in_t : newest_t;
  assign wmax   = (win_eta > win_rate) ? win_eta : win_rate;
  assign le_m   = $signed({2'b0, rd_t}) <= edge_m;
  assign le_r   = $signed({2'b0, rd_t}) <= edge_r;
  assign le_e   = $signed({2'b0, rd_t}) <= edge_e;

  always_ff @(posedge clk) begin
    if (accept && ins) begin
      mem_t[wslot] <= in_t;
      mem_b[wslot] <= in_b;
    end
    rd_t <= mem_t[raddr];
    rd_b <= mem_b[raddr];
  end

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      win_eta    <= swre_pkg::WIN_ETA_RST;
      win_rate   <= swre_pkg::WIN_RATE_RST;
      data_total <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        swre_pkg::REG_WIN_ETA:    win_eta    <= pwdata[swre_pkg::WIN_W-1:0];
        swre_pkg::REG_WIN_RATE:   win_rate   <= pwdata[swre_pkg::WIN_W-1:0];
        swre_pkg::REG_DATA_TOTAL: data_total <= pwdata[swre_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      swre_pkg::REG_WIN_ETA:    prdata = {44'b0, win_eta};
      swre_pkg::REG_WIN_RATE:   prdata = {44'b0, win_rate};
      swre_pkg::REG_DATA_TOTAL: prdata = {16'b0, data_total};
      default:                  prdata = '0;
    endcase
  end

  // Shared multiplier and divider operands.
  logic [swre_pkg::BYTES_W-1:0] mul_a, adb, arem;
  logic [swre_pkg::MUL_B_W-1:0] mul_b;
  logic neg;
  logic div_start, div_done;
  logic [swre_pkg::NUM_W-1:0] div_num, div_quo;
  logic [swre_pkg::DEN_W-1:0] div_den;

  assign neg  = rem[swre_pkg::BYTES_W] ^ db_e[swre_pkg::BYTES_W];
  assign adb  = db_e[swre_pkg::BYTES_W] ? swre_pkg::BYTES_W'(-db_e)
                                         : db_e[swre_pkg::BYTES_W-1:0];
  assign arem = rem[swre_pkg::BYTES_W] ? swre_pkg::BYTES_W'(-rem)
                                        : rem[swre_pkg::BYTES_W-1:0];

  always_comb begin
    case (state)
      MR:      begin mul_a = db_r[swre_pkg::BYTES_W-1:0]; mul_b = swre_pkg::MS_PER_SEC; end
      ME:      begin mul_a = adb;  mul_b = swre_pkg::MS_PER_SEC; end
      ME2:     begin mul_a = arem; mul_b = dt_e[15:0]; end
      default: begin mul_a = arem; mul_b = dt_e[31:16]; end
    endcase
  end

  assign div_start = (state == DR) || (state == DE);
  assign div_num = (state == DR) ? {22'b0, prod[swre_pkg::DEN_W-1:0]} : acc;
  assign div_den = (state == DR) ? {26'b0, dt_r} : den_e;

  swre_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic [swre_pkg::NUM_W-1:0] eta_cap;
  logic [31:0] eta_mag;
  assign eta_cap = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
  assign eta_mag = (div_quo > eta_cap) ? eta_cap[31:0] : div_quo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      oldest        <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != OUT) m_axis_tvalid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            if (ins) begin
              newest_t <= in_t;
              newest_b <= in_b;
              if (full) oldest <= slot(oldest, CW'(1));
              else count <= count + CW'(1);
            end
            edge_m  <= $signed({2'b0, nt}) - $signed({14'b0, wmax});
            edge_r  <= $signed({2'b0, nt}) - $signed({14'b0, win_rate});
            edge_e  <= $signed({2'b0, nt}) - $signed({14'b0, win_eta});
            iss     <= '0;
            proc    <= '0;
            kcnt    <= '0;
            rd_pend <= 1'b0;
            state   <= SCAN;
          end
        end
        SCAN: begin
          rd_pend <= (iss < count);
          if (iss < count) iss <= iss + CW'(1);
          if (rd_pend) begin
            proc <= proc + CW'(1);
            if (le_m) kcnt <= kcnt + CW'(1);
            if (proc == '0 || le_r) begin frt_r <= rd_t; frb_r <= rd_b; end
            if (proc == '0 || le_e) begin frt_e <= rd_t; frb_e <= rd_b; end
            if (proc + CW'(1) == count) state <= EVICT;
          end
        end
        EVICT: begin
          if (kcnt >= CW'(2)) begin
            oldest <= slot(oldest, kcnt - CW'(1));
            count  <= count - (kcnt - CW'(1));
          end
          state <= CALC;
        end
        CALC: begin
          dt_r  <= newest_t - frt_r;
          dt_e  <= newest_t - frt_e;
          db_r  <= {1'b0, newest_b} - {1'b0, frb_r};
          db_e  <= {1'b0, newest_b} - {1'b0, frb_e};
          rem   <= {1'b0, data_total} - {1'b0, newest_b};
          state <= MR;
        end
        MR: begin
          if (dt_r != '0 && !db_r[swre_pkg::BYTES_W] && db_r != '0) begin
            prod  <= mul_a * mul_b;
            state <= DR;
          end else begin
            rate_q    <= '0;
            rate_ok_r <= 1'b0;
            state     <= ME;
          end
        end
        DR: state <= DRW;
        DRW: begin
          if (div_done) begin
            rate_q    <= (div_quo[79:48] != '0) ? '1 : div_quo[47:0];
            rate_ok_r <= 1'b1;
            state     <= ME;
          end
        end
        ME: begin
          if (db_e != '0) begin
            prod  <= mul_a * mul_b;
            state <= ME2;
          end else begin
            eta_q    <= '0;
            eta_ok_r <= 1'b0;
            state    <= OUT;
          end
        end
        ME2: begin
          den_e <= prod[swre_pkg::DEN_W-1:0];
          prod  <= mul_a * mul_b;
          state <= ME3;
        end
        ME3: begin
          acc   <= {16'b0, prod};
          prod  <= mul_a * mul_b;
          state <= ME4;
        end
        ME4: begin
          acc   <= acc + {prod, 16'b0};
          state <= DE;
        end
        DE: state <= DEW;
        DEW: begin
          if (div_done) begin
            eta_q    <= neg ? (32'd0 - eta_mag) : eta_mag;
            eta_ok_r <= 1'b1;
            state    <= OUT;
          end
        end
        OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {eta_q, rate_q};
            m_axis_tuser  <= {eta_ok_r, rate_ok_r};
            m_axis_tvalid <= 1'b1;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: sv/swre_chk.sv
module swre_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled output beat changed.");

  a_rate_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[47:0] == 48'd0)
    else $error("Rate is nonzero while not valid.");

  a_eta_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[79:48] == 32'd0)
    else $error("Remaining time is nonzero while not valid.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input ready right after a sample was taken.");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("Block not idle after reset.");

endmodule

bind sliding_window_rate_eta_core swre_chk u_swre_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
